@@ hw/rtl/dsls_pkg.sv @@
// Shared types and constants for the DAC slope learning stepper.
// No dependencies; used by dsls_score_upd and the top level.
package dsls_pkg;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_SET_CLR = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam int DAC_RESET_LEVEL = 17922;
  localparam logic signed [8:0] SCORE_LIMIT   = 9'sd127;
  localparam logic signed [5:0] SCORE_STEP    = 6'sd4;
  localparam logic signed [5:0] SCORE_PENALTY = 6'sd16;
  localparam logic [33:0]       GROWTH_MARGIN = 34'd20;

endpackage

@@ hw/rtl/dac_slope_learning_stepper_unit.sv @@
// DAC slope learning stepper, top level: sequencer, score memory, history ring.
// Depends on dsls_pkg and dsls_score_upd.
//
// Usage: drive a request on in_* with start high; it is taken when busy is low.
// One result appears on out_* for exactly one cycle with out_valid high; the
// receiver cannot stall it, so sample it then.
// Commands: observe pushes the error into the history ring, settles a due
// trial by read-modify-write of the slope score memory (up to four updates)
// and may take a learned +/-1 step (up to three score reads). Load sets the
// DAC; set and clear wipe the learner.
// Observe time grows with the score updates and direction reads it needs,
// which share the single score memory read port.
// Set and clear sweep the score memory one entry per cycle, busy throughout.
// Reset: rst_n (synchronous, active low) restores the DAC to its reset level
// and starts the same sweep with no result; start is ignored until busy
// drops. cfg_ready stays high; write eval_window only while idle.
module dac_slope_learning_stepper_unit #(
  parameter int DAC_FULL_SCALE = 32768,
  parameter int HISTORY_DEPTH  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_qerr_ps,
  input  logic               in_step_enable,
  input  logic [15:0]        in_dac_value,
  output logic               out_valid,
  output logic [15:0]        out_dac_level,
  output logic signed [1:0]  out_step_taken,
  output logic               out_evaluation_done,
  output logic               out_trial_pending,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  localparam int AW = $clog2(DAC_FULL_SCALE + 1);
  localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [15:0] FS16 = 16'(DAC_FULL_SCALE);
  localparam logic [AW-1:0] FS_A = AW'(DAC_FULL_SCALE);
  localparam logic [15:0] DAC_RST = (dsls_pkg::DAC_RESET_LEVEL > DAC_FULL_SCALE) ?
                                    16'(DAC_FULL_SCALE) : 16'(dsls_pkg::DAC_RESET_LEVEL);
  localparam logic [HW+1:0] HD_S = (HW+2)'(HISTORY_DEPTH);
  localparam logic [HW-1:0] HD_LAST = HW'(HISTORY_DEPTH - 1);
  localparam logic [FW-1:0] HD_F = FW'(HISTORY_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_HCHK, S_PEN, S_URD, S_UWR, S_STEP,
    S_CRD, S_CCHK, S_APPLY, S_CLR, S_DONE
  } state_t;

  state_t state_r;

  // request capture
  logic signed [31:0] err_r;
  logic               en_r;

  // learner state
  logic [HW-1:0]      pos_r;
  logic [FW-1:0]      fill_r;
  logic [15:0]        dac_r;
  logic               pend_r;
  logic [7:0]         wc_r;
  logic [7:0]         wl_r;
  logic [15:0]        tfd_r;
  logic signed [31:0] terr_r;
  logic signed [1:0]  tstep_r;
  logic [7:0]         ew_r;

  // sequencer scratch
  logic               use_hist_r;
  logic               ls_neg_r;
  logic               pen_r;
  logic [1:0]         op_r;
  logic [1:0]         cidx_r;
  logic               slope_neg_r;
  logic [AW-1:0]      clr_r;
  logic               clr_report_r;
  logic signed [1:0]  step_r;
  logic               done_r;

  // memories
  logic [7:0]  score_mem [DAC_FULL_SCALE + 1];
  logic [31:0] hist_mem  [HISTORY_DEPTH];
  logic [7:0]  score_rd_r;
  logic [31:0] hist_rd_r;
  logic [AW-1:0] score_raddr;
  logic [AW-1:0] score_waddr;
  logic [7:0]    score_wdata;
  logic          score_we;
  logic [AW-1:0] op_addr;

  logic signed [5:0] change;
  logic signed [7:0] upd_score;

  logic [HW+1:0] hsum;
  logic [HW-1:0] hidx;
  logic [FW-1:0] fill_nxt;
  logic [HW-1:0] pos_nxt;
  logic [7:0]    wc_nxt;

  logic signed [32:0] past_x;
  logic signed [32:0] dq;
  logic [32:0] abs_now;
  logic [32:0] abs_prev;
  logic        sgn_eq;
  logic        grew;
  logic [15:0] lvl_sat;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_DONE);
  assign out_dac_level       = dac_r;
  assign out_step_taken      = step_r;
  assign out_evaluation_done = done_r;
  assign out_trial_pending   = pend_r;

  assign lvl_sat = (in_dac_value > FS16) ? FS16 : in_dac_value;

  // history ring bookkeeping: the window entry sits wl_r behind the write slot
  always_comb begin
    hsum = (HW+2)'(pos_r) + HD_S - (HW+2)'(wl_r);
    if (hsum >= HD_S) begin
      hsum = hsum - HD_S;
    end
    hidx     = hsum[HW-1:0];
    fill_nxt = (fill_r < HD_F) ? fill_r + 1'b1 : fill_r;
    pos_nxt  = (pos_r == HD_LAST) ? '0 : pos_r + 1'b1;
    wc_nxt   = (wc_r != 8'd0) ? wc_r - 8'd1 : 8'd0;
  end

  // settle arithmetic
  always_comb begin
    past_x   = use_hist_r ? {hist_rd_r[31], hist_rd_r} : {terr_r[31], terr_r};
    dq       = {err_r[31], err_r} - past_x;
    abs_now  = err_r[31] ? 33'(-{err_r[31], err_r}) : {1'b0, err_r};
    abs_prev = terr_r[31] ? 33'(-{terr_r[31], terr_r}) : {1'b0, terr_r};
    sgn_eq   = (err_r[31] == terr_r[31]) && ((err_r == 32'sd0) == (terr_r == 32'sd0));
    grew     = {1'b0, abs_now} > ({1'b0, abs_prev} + dsls_pkg::GROWTH_MARGIN);
  end

  // score update unit: ops 0,1 apply the learned sign, ops 2,3 the penalty
  always_comb begin
    op_addr = op_r[0] ? tfd_r[AW-1:0] : dac_r[AW-1:0];
    if (op_r[1]) begin
      change = ls_neg_r ? dsls_pkg::SCORE_PENALTY : -dsls_pkg::SCORE_PENALTY;
    end else begin
      change = ls_neg_r ? -dsls_pkg::SCORE_STEP : dsls_pkg::SCORE_STEP;
    end
  end

  dsls_score_upd u_upd (
    .score_i  (score_rd_r),
    .change_i (change),
    .score_o  (upd_score)
  );

  always_comb begin
    score_raddr = op_addr;
    score_waddr = op_addr;
    score_wdata = upd_score;
    score_we    = 1'b0;
    case (state_r)
      S_CRD: begin
        case (cidx_r)
          2'd1:    score_raddr = AW'(dac_r - 16'd1);
          2'd2:    score_raddr = AW'(dac_r + 16'd1);
          default: score_raddr = dac_r[AW-1:0];
        endcase
      end
      S_UWR: score_we = 1'b1;
      S_CLR: begin
        score_we    = 1'b1;
        score_waddr = clr_r;
        score_wdata = 8'd0;
      end
      default: score_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[score_waddr] <= score_wdata;
    end
    score_rd_r <= score_mem[score_raddr];
    if (state_r == S_PUSH) begin
      hist_mem[pos_r] <= err_r;
    end
    hist_rd_r <= hist_mem[hidx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      clr_report_r <= 1'b0;
      pos_r        <= '0;
      fill_r       <= '0;
      dac_r        <= DAC_RST;
      pend_r       <= 1'b0;
      wc_r         <= 8'd0;
      wl_r         <= 8'd0;
      tfd_r        <= 16'd0;
      terr_r       <= 32'sd0;
      tstep_r      <= 2'sd0;
      ew_r         <= 8'd4;
      step_r       <= 2'sd0;
      done_r       <= 1'b0;
      use_hist_r   <= 1'b0;
      ls_neg_r     <= 1'b0;
      pen_r        <= 1'b0;
      op_r         <= 2'd0;
      cidx_r       <= 2'd0;
      slope_neg_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ew_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            err_r  <= in_qerr_ps;
            en_r   <= in_step_enable;
            step_r <= 2'sd0;
            done_r <= 1'b0;
            case (dsls_pkg::cmd_t'(in_command))
              dsls_pkg::CMD_OBSERVE: state_r <= S_PUSH;
              dsls_pkg::CMD_LOAD: begin
                dac_r   <= lvl_sat;
                state_r <= S_DONE;
              end
              default: begin
                // wipe the learner, then sweep the score memory
                pos_r        <= '0;
                fill_r       <= '0;
                pend_r       <= 1'b0;
                wc_r         <= 8'd0;
                wl_r         <= 8'd0;
                tfd_r        <= 16'd0;
                terr_r       <= 32'sd0;
                tstep_r      <= 2'sd0;
                clr_r        <= '0;
                clr_report_r <= 1'b1;
                if (dsls_pkg::cmd_t'(in_command) == dsls_pkg::CMD_SET_CLR) begin
                  dac_r <= lvl_sat;
                end
                state_r <= S_CLR;
              end
            endcase
          end
        end
        S_PUSH: begin
          // push the error, advance the ring, count down the trial window
          pos_r      <= pos_nxt;
          fill_r     <= fill_nxt;
          use_hist_r <= ({1'b0, wl_r} < 9'(fill_nxt));
          if (pend_r) begin
            wc_r <= wc_nxt;
            if (wc_nxt == 8'd0) begin
              state_r <= S_HCHK;
            end else begin
              state_r <= S_STEP;
            end
          end else begin
            state_r <= S_STEP;
          end
        end
        S_HCHK: begin
          ls_neg_r <= !((dq > 33'sd0 && tstep_r > 2'sd0) || (dq < 33'sd0 && tstep_r < 2'sd0));
          op_r     <= 2'd0;
          if (tstep_r != 2'sd0 && dq != 33'sd0) begin
            state_r <= S_PEN;
          end else begin
            pend_r  <= 1'b0;
            wc_r    <= 8'd0;
            wl_r    <= 8'd0;
            tstep_r <= 2'sd0;
            done_r  <= 1'b1;
            state_r <= S_STEP;
          end
        end
        S_PEN: begin
          pen_r   <= sgn_eq && grew;
          state_r <= S_URD;
        end
        S_URD: state_r <= S_UWR;
        S_UWR: begin
          if (op_r == 2'd3 || (op_r == 2'd1 && !pen_r)) begin
            pend_r  <= 1'b0;
            wc_r    <= 8'd0;
            wl_r    <= 8'd0;
            tstep_r <= 2'sd0;
            done_r  <= 1'b1;
            state_r <= S_STEP;
          end else begin
            op_r    <= op_r + 2'd1;
            state_r <= S_URD;
          end
        end
        S_STEP: begin
          cidx_r <= 2'd0;
          if (en_r && !pend_r && err_r != 32'sd0) begin
            state_r <= S_CRD;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CRD: state_r <= S_CCHK;
        S_CCHK: begin
          // take the first nonzero score at level, below, above; default to a positive slope
          if (score_rd_r != 8'd0) begin
            slope_neg_r <= score_rd_r[7];
            state_r     <= S_APPLY;
          end else if (cidx_r == 2'd0 && dac_r != 16'd0) begin
            cidx_r  <= 2'd1;
            state_r <= S_CRD;
          end else if (cidx_r != 2'd2 && dac_r < FS16) begin
            cidx_r  <= 2'd2;
            state_r <= S_CRD;
          end else begin
            slope_neg_r <= 1'b0;
            state_r     <= S_APPLY;
          end
        end
        S_APPLY: begin
          state_r <= S_DONE;
          if (err_r[31] != slope_neg_r) begin
            if (dac_r < FS16) begin
              dac_r   <= dac_r + 16'd1;
              step_r  <= 2'sd1;
              tstep_r <= 2'sd1;
              pend_r  <= 1'b1;
              wl_r    <= (ew_r == 8'd0) ? 8'd1 : ew_r;
              wc_r    <= (ew_r == 8'd0) ? 8'd1 : ew_r;
              tfd_r   <= dac_r;
              terr_r  <= err_r;
            end
          end else begin
            if (dac_r != 16'd0) begin
              dac_r   <= dac_r - 16'd1;
              step_r  <= -2'sd1;
              tstep_r <= -2'sd1;
              pend_r  <= 1'b1;
              wl_r    <= (ew_r == 8'd0) ? 8'd1 : ew_r;
              wc_r    <= (ew_r == 8'd0) ? 8'd1 : ew_r;
              tfd_r   <= dac_r;
              terr_r  <= err_r;
            end
          end
        end
        S_CLR: begin
          if (clr_r == FS_A) begin
            state_r <= clr_report_r ? S_DONE : S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_step_taken != 2'b10) else $error("illegal step code");
  a_step_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_taken != 2'sd0) |-> out_trial_pending)
    else $error("step taken without a pending trial");
  a_dac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dac_level <= FS16) else $error("DAC level above full scale");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request taken but not busy");
`endif

endmodule

@@ hw/rtl/dsls_score_upd.sv @@
// Score update unit: decay toward zero, add change, clamp to the score limit.
// Depends on dsls_pkg.
module dsls_score_upd (
  input  logic signed [7:0] score_i,
  input  logic signed [5:0] change_i,
  output logic signed [7:0] score_o
);

  logic signed [8:0] dec;
  logic signed [8:0] sum;

  always_comb begin
    dec = {score_i[7], score_i};
    if (score_i > 8'sd0) begin
      dec = dec - 9'sd1;
    end else if (score_i < 8'sd0) begin
      dec = dec + 9'sd1;
    end
    sum = dec + {{3{change_i[5]}}, change_i};
    if (sum > dsls_pkg::SCORE_LIMIT) begin
      score_o = 8'(dsls_pkg::SCORE_LIMIT);
    end else if (sum < -dsls_pkg::SCORE_LIMIT) begin
      score_o = 8'(-dsls_pkg::SCORE_LIMIT);
    end else begin
      score_o = sum[7:0];
    end
  end

endmodule

@@ dv/tb_dac_slope_learning_stepper_unit.sv @@
// Self-checking testbench for the DAC slope learning stepper top level.
// Depends on dsls_pkg and the dac_slope_learning_stepper_unit RTL; has its own predictor.
module tb_dac_slope_learning_stepper_unit;

  localparam int FULL_SCALE   = 32768;
  localparam int RING_DEPTH   = 64;
  localparam int IDLE_LIMIT   = 120000;  // must outlast a clear sweep, during which nothing is accepted

  typedef struct {
    dsls_pkg::cmd_t     cmd;
    logic signed [31:0] qerr;
    logic               step_en;
    logic [15:0]        dac;
  } request_t;

  typedef struct {
    logic [15:0]       level;
    logic signed [1:0] step;
    logic              settled;
    logic              pending;
  } level_report_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_command;
  logic signed [31:0] in_qerr_ps;
  logic               in_step_enable;
  logic [15:0]        in_dac_value;
  logic               out_valid;
  logic [15:0]        out_dac_level;
  logic signed [1:0]  out_step_taken;
  logic               out_evaluation_done;
  logic               out_trial_pending;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;

  dac_slope_learning_stepper_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_qerr_ps(in_qerr_ps),
    .in_step_enable(in_step_enable), .in_dac_value(in_dac_value),
    .out_valid(out_valid), .out_dac_level(out_dac_level),
    .out_step_taken(out_step_taken), .out_evaluation_done(out_evaluation_done),
    .out_trial_pending(out_trial_pending),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state: a private copy of the learner.
  logic signed [7:0]  slope_mem [0:FULL_SCALE];
  logic signed [31:0] err_ring [0:RING_DEPTH-1];
  int unsigned        ring_pos, ring_fill;
  int unsigned        dac_lvl;
  bit                 trial_armed;
  int unsigned        trial_wait, trial_window, trial_dac;
  int                 trial_err, trial_dir;
  int unsigned        window_cfg;

  request_t      request_q[$];
  level_report_t level_q[$];
  int            fail_count;
  int            burst_left, gap_left, idle_cycles;

  function automatic int sgn(longint x);
    return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
  endfunction

  function automatic void wipe_learner();
    for (int i = 0; i <= FULL_SCALE; i++) slope_mem[i] = '0;
    ring_pos = 0; ring_fill = 0;
    trial_armed = 0; trial_wait = 0; trial_window = 0;
    trial_dac = 0; trial_err = 0; trial_dir = 0;
  endfunction

  // Decay one toward zero, add the change, clamp to +/-127.
  function automatic void nudge_slope(int unsigned lvl, int change);
    int s;
    if (lvl > FULL_SCALE || change == 0) return;
    s = slope_mem[lvl];
    if (s > 0) s--;
    else if (s < 0) s++;
    s += change;
    if (s > 127) s = 127;
    if (s < -127) s = -127;
    slope_mem[lvl] = s[7:0];
  endfunction

  function automatic level_report_t predict_level(request_t r);
    level_report_t res;
    int unsigned   lvl, idx;
    longint        past, dq, old_mag, now_abs;
    int            ls, slope, want;
    bit            settled;
    lvl = (r.dac > FULL_SCALE) ? FULL_SCALE : r.dac;
    want = 0;
    settled = 0;
    case (r.cmd)
      dsls_pkg::CMD_OBSERVE: begin
        err_ring[ring_pos] = r.qerr;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        // Settle a pending trial once its window has run out.
        if (trial_armed) begin
          trial_wait = (trial_wait > 0) ? trial_wait - 1 : 0;
          if (trial_wait == 0) begin
            past = trial_err;
            if (trial_window < ring_fill) begin
              idx = (ring_pos + RING_DEPTH - 1 - trial_window) % RING_DEPTH;
              past = err_ring[idx];
            end
            dq = longint'(r.qerr) - past;
            if (trial_dir != 0 && dq != 0) begin
              ls = (sgn(dq) * trial_dir > 0) ? 1 : -1;
              old_mag = (trial_err < 0) ? -longint'(trial_err) : longint'(trial_err);
              now_abs = (r.qerr < 0) ? -longint'(r.qerr) : longint'(r.qerr);
              nudge_slope(dac_lvl, ls * 4);
              nudge_slope(trial_dac, ls * 4);
              if (sgn(trial_err) == sgn(r.qerr) && now_abs > old_mag + 20) begin
                nudge_slope(dac_lvl, -ls * 16);
                nudge_slope(trial_dac, -ls * 16);
              end
            end
            trial_armed = 0; trial_wait = 0; trial_window = 0; trial_dir = 0;
            settled = 1;
          end
        end
        // Step against the error along the learned slope.
        if (r.step_en && !trial_armed) begin
          slope = sgn(slope_mem[dac_lvl]);
          if (slope == 0 && dac_lvl > 0) slope = sgn(slope_mem[dac_lvl-1]);
          if (slope == 0 && dac_lvl < FULL_SCALE) slope = sgn(slope_mem[dac_lvl+1]);
          if (slope == 0) slope = 1;
          want = -sgn(r.qerr) * slope;
          if (dac_lvl == 0 && want < 0) want = 0;
          if (dac_lvl >= FULL_SCALE && want > 0) want = 0;
          if (want != 0) begin
            trial_dac = dac_lvl;
            dac_lvl = dac_lvl + want;
            trial_armed = 1;
            trial_window = (window_cfg == 0) ? 1 : window_cfg;
            trial_wait = trial_window;
            trial_err = r.qerr;
            trial_dir = want;
          end
        end
      end
      dsls_pkg::CMD_LOAD: dac_lvl = lvl;
      dsls_pkg::CMD_SET_CLR: begin
        wipe_learner();
        dac_lvl = lvl;
      end
      default: wipe_learner();
    endcase
    res.level = dac_lvl[15:0];
    res.step = want[1:0];
    res.settled = settled;
    res.pending = trial_armed;
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver: issue requests in bursts with random gaps; hold while busy.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_command <= dsls_pkg::CMD_OBSERVE;
      in_qerr_ps <= '0;
      in_step_enable <= 0;
      in_dac_value <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      if (start) begin
        request_t taken;
        taken.cmd = dsls_pkg::cmd_t'(in_command);
        taken.qerr = in_qerr_ps;
        taken.step_en = in_step_enable;
        taken.dac = in_dac_value;
        level_q.push_back(predict_level(taken));
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 0;
      end else if (request_q.size() > 0) begin
        request_t nxt;
        nxt = request_q.pop_front();
        in_command <= nxt.cmd;
        in_qerr_ps <= nxt.qerr;
        in_step_enable <= nxt.step_en;
        in_dac_value <= nxt.dac;
        start <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 0;
      end
    end
  end

  // Monitor: check every strobed result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (level_q.size() == 0) begin
        $error("unexpected result: dac_level %0d", out_dac_level);
        fail_count++;
      end else begin
        level_report_t exp_r;
        exp_r = level_q.pop_front();
        if (out_dac_level !== exp_r.level) begin
          $error("dac_level expected %0d actual %0d", exp_r.level, out_dac_level);
          fail_count++;
        end
        if (out_step_taken !== exp_r.step) begin
          $error("step_taken expected %0d actual %0d", exp_r.step, out_step_taken);
          fail_count++;
        end
        if (out_evaluation_done !== exp_r.settled) begin
          $error("evaluation_done expected %0b actual %0b", exp_r.settled,
                 out_evaluation_done);
          fail_count++;
        end
        if (out_trial_pending !== exp_r.pending) begin
          $error("trial_pending expected %0b actual %0b", exp_r.pending, out_trial_pending);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_request(dsls_pkg::cmd_t c, logic signed [31:0] q, logic en,
                              logic [15:0] d);
    request_t r;
    r.cmd = c; r.qerr = q; r.step_en = en; r.dac = d;
    request_q.push_back(r);
  endtask

  // Wait until every request is taken, answered, and the block is idle.
  task automatic drain();
    do @(negedge clk);
    while (request_q.size() > 0 || start || level_q.size() > 0 || busy);
  endtask

  task automatic write_window(logic [7:0] w);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    window_cfg = w;
    cfg_valid <= 0;
  endtask

  // Small errors dominate so growth and sign rules fire; extremes hit the bit edges.
  function automatic logic signed [31:0] pick_error();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return $urandom;
    if (k == 1) return 0;
    if (k == 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (k < 6) return $signed($urandom_range(0, 4000)) - 2000;
    return $signed($urandom_range(0, 120)) - 60;
  endfunction

  function automatic logic [15:0] pick_level();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'($urandom_range(0, 2));
    if (k == 2) return 16'($urandom_range(FULL_SCALE - 2, FULL_SCALE));
    return 16'($urandom_range(0, FULL_SCALE));
  endfunction

  task automatic add_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 999);
      // Keep clears rare: each one sweeps the whole score memory.
      if (r < 2) push_request(dsls_pkg::CMD_SET_CLR, pick_error(),
                              1'($urandom_range(0, 1)), pick_level());
      else if (r < 4) push_request(dsls_pkg::CMD_CLEAR, pick_error(),
                                   1'($urandom_range(0, 1)), pick_level());
      else if (r < 60) push_request(dsls_pkg::CMD_LOAD, pick_error(),
                                    1'($urandom_range(0, 1)), pick_level());
      else push_request(dsls_pkg::CMD_OBSERVE, pick_error(), (r % 10) != 0,
                        16'($urandom));
    end
  endtask

  initial begin
    logic [7:0] windows [6];
    cfg_valid = 0;
    cfg_data = '0;
    window_cfg = 4;
    rst_n = 0;
    dac_lvl = dsls_pkg::DAC_RESET_LEVEL;
    wipe_learner();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    drain();
    write_window(8'd4);

    // Directed: every command, field extremes, clamps at both ends of the DAC.
    push_request(dsls_pkg::CMD_OBSERVE, 32'sh7fffffff, 1'b1, 16'hffff);
    push_request(dsls_pkg::CMD_OBSERVE, 32'sh80000000, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 0, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 100, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 150, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_LOAD, 0, 1'b0, 16'd0);
    push_request(dsls_pkg::CMD_OBSERVE, 40, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, -40, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_LOAD, 0, 1'b0, 16'hffff);
    push_request(dsls_pkg::CMD_OBSERVE, -40, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 40, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 30, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_LOAD, 0, 1'b0, 16'd32767);
    push_request(dsls_pkg::CMD_OBSERVE, 10, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 90, 1'b0, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 90, 1'b0, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 90, 1'b0, 16'h0000);
    push_request(dsls_pkg::CMD_OBSERVE, 90, 1'b0, 16'h0000);
    push_request(dsls_pkg::CMD_SET_CLR, -1, 1'b1, 16'd1);
    push_request(dsls_pkg::CMD_OBSERVE, -5, 1'b1, 16'h0000);
    push_request(dsls_pkg::CMD_CLEAR, 5, 1'b1, 16'd500);
    push_request(dsls_pkg::CMD_OBSERVE, 0, 1'b0, 16'h0000);
    drain();

    // Random phases, one window setting each.
    windows[0] = 8'd1;
    windows[1] = 8'd255;
    windows[2] = 8'd2;
    windows[3] = 8'd63;
    windows[4] = 8'd64;
    windows[5] = 8'($urandom_range(1, 255));
    foreach (windows[p]) begin
      write_window(windows[p]);
      @(negedge clk);
      add_random(246);
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && level_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
